FILE: src/i2cbm_pkg.sv
// Shared types, phase codes and constants of the I2C byte master.
package i2cbm_pkg;

    // Default width of the unit timer
    localparam int I2CBM_TIMER_BITS = 16;

    // Configuration register
    localparam int          UNIT_BITS        = 16;
    localparam logic [15:0] UNIT_TICKS_RESET = 16'd200;

    // Command codes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_STOP  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    // Phase codes; phases not listed only advance to the next code
    localparam int         PH_BITS      = 5;
    localparam logic [4:0] PH_IDLE      = 5'd0;
    localparam logic [4:0] PH_START     = 5'd1;
    localparam logic [4:0] PH_START_SDA = 5'd2;
    localparam logic [4:0] PH_START_SCL = 5'd4;
    localparam logic [4:0] PH_STOP      = 5'd5;
    localparam logic [4:0] PH_STOP_SCL  = 5'd6;
    localparam logic [4:0] PH_STOP_SDA  = 5'd8;
    localparam logic [4:0] PH_STOP_END  = 5'd10;
    localparam logic [4:0] PH_WBIT      = 5'd11;
    localparam logic [4:0] PH_WBIT_SCL  = 5'd12;
    localparam logic [4:0] PH_WBIT_END  = 5'd14;
    localparam logic [4:0] PH_WACK      = 5'd15;
    localparam logic [4:0] PH_WACK_SCL  = 5'd16;
    localparam logic [4:0] PH_WACK_END  = 5'd18;
    localparam logic [4:0] PH_RBIT      = 5'd19;
    localparam logic [4:0] PH_RBIT_SCL  = 5'd20;
    localparam logic [4:0] PH_RBIT_END  = 5'd22;
    localparam logic [4:0] PH_RACK      = 5'd23;
    localparam logic [4:0] PH_RACK_SCL  = 5'd24;
    localparam logic [4:0] PH_RACK_END  = 5'd26;

    // Bits in one data byte
    localparam logic [3:0] BYTE_BITS = 4'd8;

    // One tick of input
    typedef struct packed {
        logic       cmd_valid;
        logic [1:0] mode;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } tick_t;

    // One result word
    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       slave_nack;
    } res_t;

endpackage

FILE: src/i2c_bitbang_byte_master_core.sv
// Top level of the byte-level open-drain I2C master.
//
// Usage: each word on the tick channel is one tick of the bus timing engine,
// carrying an optional command (start, stop, write, read) and the sampled SDA
// level. Every accepted tick yields exactly one word on the result channel
// with the SCL and SDA pull-low drives, busy, done, the last received byte
// and the slave acknowledge of the last write. Commands offered while busy
// are ignored.
// The cfg channel writes the unit length in ticks; cfg_ready is always high
// and writes are meant for idle periods only.
// The result word of a tick is registered and appears in the cycle after
// acceptance. One tick is taken per cycle unless tick_stall is high; the
// whole step is one pass through the phase sequencer and unit timer compare
// between the state registers and the result register.
// Reset clears the sequencer to idle, releases both lines and loads a unit
// length of 200 ticks. When the receiver stalls, the result register holds
// its word and tick_stall rises, so no further tick is taken until the word
// leaves.
module i2c_bitbang_byte_master_core
    import i2cbm_pkg::*;
#(
    parameter int TIMER_BITS = I2CBM_TIMER_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [UNIT_BITS-1:0] cfg_data,
    input  logic                 tick_valid,
    output logic                 tick_stall,
    input  tick_t                tick_word,
    output logic                 res_valid,
    input  logic                 res_stall,
    output res_t                 res_word
);

    logic accept;
    res_t step_res;

    // Stall only while a waiting word cannot leave
    assign tick_stall = res_valid && res_stall;
    assign accept     = tick_valid && !tick_stall;
    assign cfg_ready  = 1'b1;

    i2cbm_engine #(
        .TIMER_BITS(TIMER_BITS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .step     (accept),
        .tick     (tick_word),
        .res      (step_res)
    );

    i2cbm_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .word_in   (step_res),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res_word  (res_word)
    );

endmodule

FILE: src/i2cbm_engine.sv
// Bus timing engine: phase sequencer, unit timer, shifter and line drives.
module i2cbm_engine
    import i2cbm_pkg::*;
#(
    parameter int TIMER_BITS = I2CBM_TIMER_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [UNIT_BITS-1:0] cfg_data,
    input  logic                 step,
    input  tick_t                tick,
    output res_t                 res
);

    localparam int CW = (TIMER_BITS > UNIT_BITS) ? TIMER_BITS : UNIT_BITS;

    logic [UNIT_BITS-1:0]  unit_ticks_reg;
    logic [PH_BITS-1:0]    phase_reg, phase_next;
    logic [3:0]            bit_count_reg, bit_count_next;
    logic [7:0]            shift_reg, shift_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;
    logic                  ack_reg, ack_next;
    logic                  nack_reg, nack_next;
    logic [7:0]            rx_hold_reg, rx_hold_next;

    logic [CW-1:0]         unit_raw;
    logic [CW-1:0]         unit_lim;
    logic [CW-1:0]         unit_len;
    logic [TIMER_BITS-1:0] timer_inc;
    logic                  unit_hit;
    logic                  fin;
    logic [PH_BITS-1:0]    phase_adv;
    logic [3:0]            count_inc;
    logic [7:0]            shift_in;

    // Clamp the unit length to at least one tick and at most the timer range
    always_comb
    begin
        unit_raw = CW'(unit_ticks_reg);
        unit_lim = CW'({TIMER_BITS{1'b1}});
        if (unit_raw == '0)
        begin
            unit_len = CW'(1);
        end
        else if (unit_raw > unit_lim)
        begin
            unit_len = unit_lim;
        end
        else
        begin
            unit_len = unit_raw;
        end
    end

    assign timer_inc = timer_reg + TIMER_BITS'(1);
    assign unit_hit  = (CW'(timer_inc) >= unit_len);
    assign phase_adv = phase_reg + PH_BITS'(1);
    assign count_inc = bit_count_reg + 4'd1;
    assign shift_in  = {shift_reg[6:0], tick.sda_in};

    // Work out the state after this tick
    always_comb
    begin
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        timer_next     = timer_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        ack_next       = ack_reg;
        nack_next      = nack_reg;
        rx_hold_next   = rx_hold_reg;
        fin            = 1'b0;
        if (phase_reg == PH_IDLE)
        begin
            if (tick.cmd_valid)
            begin
                timer_next     = '0;
                bit_count_next = 4'd0;
                case (tick.mode)
                    MODE_START:
                    begin
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        phase_next = PH_START;
                    end
                    MODE_STOP:
                    begin
                        sda_next   = 1'b1;
                        phase_next = PH_STOP;
                    end
                    MODE_WRITE:
                    begin
                        shift_next = tick.tx_byte;
                        phase_next = PH_WBIT;
                    end
                    default:
                    begin
                        sda_next   = 1'b0;
                        shift_next = 8'd0;
                        ack_next   = tick.send_ack;
                        phase_next = PH_RBIT;
                    end
                endcase
            end
        end
        else if (!unit_hit)
        begin
            timer_next = timer_inc;
        end
        else
        begin
            timer_next = '0;
            phase_next = phase_adv;
            case (phase_reg)
                PH_START_SDA: sda_next = 1'b1;
                PH_START_SCL:
                begin
                    scl_next = 1'b1;
                    fin      = 1'b1;
                end
                PH_STOP_SCL:  scl_next = 1'b0;
                PH_STOP_SDA:  sda_next = 1'b0;
                PH_STOP_END:  fin      = 1'b1;
                PH_WBIT:      sda_next = ~shift_reg[7];
                PH_WBIT_SCL:  scl_next = 1'b0;
                PH_WBIT_END:
                begin
                    scl_next       = 1'b1;
                    shift_next     = {shift_reg[6:0], 1'b0};
                    bit_count_next = count_inc;
                    phase_next     = (count_inc >= BYTE_BITS) ? PH_WACK : PH_WBIT;
                end
                PH_WACK:      sda_next = 1'b0;
                PH_WACK_SCL:  scl_next = 1'b0;
                PH_WACK_END:
                begin
                    nack_next = tick.sda_in;
                    scl_next  = 1'b1;
                    fin       = 1'b1;
                end
                PH_RBIT_SCL:  scl_next = 1'b0;
                PH_RBIT_END:
                begin
                    shift_next     = shift_in;
                    scl_next       = 1'b1;
                    bit_count_next = count_inc;
                    if (count_inc >= BYTE_BITS)
                    begin
                        rx_hold_next = shift_in;
                        phase_next   = PH_RACK;
                    end
                    else
                    begin
                        phase_next = PH_RBIT;
                    end
                end
                PH_RACK:      sda_next = ack_reg;
                PH_RACK_SCL:  scl_next = 1'b0;
                PH_RACK_END:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b0;
                    fin      = 1'b1;
                end
                default: ;
            endcase
            if (fin)
            begin
                phase_next = PH_IDLE;
            end
        end
    end

    // Hold the unit length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg <= UNIT_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            unit_ticks_reg <= cfg_data;
        end
    end

    // Advance the state once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_count_reg <= 4'd0;
            shift_reg     <= 8'd0;
            timer_reg     <= '0;
            scl_reg       <= 1'b0;
            sda_reg       <= 1'b0;
            ack_reg       <= 1'b0;
            nack_reg      <= 1'b0;
            rx_hold_reg   <= 8'd0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            timer_reg     <= timer_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            ack_reg       <= ack_next;
            nack_reg      <= nack_next;
            rx_hold_reg   <= rx_hold_next;
        end
    end

    // Form the result word from the state after this tick
    assign res.scl_pull_low = scl_next;
    assign res.sda_pull_low = sda_next;
    assign res.busy_res     = (phase_next != PH_IDLE);
    assign res.done_res     = fin;
    assign res.rx_byte      = rx_hold_next;
    assign res.slave_nack   = nack_next;

endmodule

FILE: src/i2cbm_out_reg.sv
// Result register that holds a word until the receiver takes it.
module i2cbm_out_reg
    import i2cbm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  res_t word_in,
    input  logic res_stall,
    output logic res_valid,
    output res_t res_word
);

    logic res_valid_reg;
    res_t res_word_reg;

    // Track whether a word is waiting
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Capture a new word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_word_reg <= word_in;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

endmodule

FILE: src/i2cbm_checker.sv
// Port-level checks of the I2C byte master and their bind to the top level.
module i2cbm_checker
    import i2cbm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic tick_valid,
    input logic tick_stall,
    input logic res_valid,
    input logic res_stall,
    input res_t res_word
);

    // A completed command leaves the engine idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_word.done_res && res_word.busy_res))
        else $error("done word still shows busy");

    // Every accepted tick produces a result word
    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && !tick_stall) |=> res_valid)
        else $error("accepted tick produced no result");

    // Stall the tick side only behind a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        tick_stall |-> (res_valid && res_stall))
        else $error("tick stalled without a blocked result");

    // A stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(res_word)))
        else $error("stalled result word changed");

endmodule

bind i2c_bitbang_byte_master_core i2cbm_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_word   (res_word)
);
